FILE: src/assert_macros.svh
// Assertion macros shared by the oscillator divider RTL.
// Define NO_ASSERTIONS to compile every macro to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define OSC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define OSC_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");
`else
`define OSC_ASSERT(lbl, clk, rstn, prop)
`define OSC_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

FILE: src/oscdiv_pkg.sv
// Types, constants and the divider table for the oscillator divider block.
// No dependencies; used by oscillator_divider_and_rfreq_calc_top.
package oscdiv_pkg;

  localparam int FREQ_W    = 32;
  localparam int FRAC_BITS = 28;
  localparam int DCO_W     = 33;
  localparam int DVD_W     = FREQ_W + FRAC_BITS + 1;
  localparam int CNT_W     = $clog2(DVD_W + 1);
  localparam int RATIO_W   = 11;
  localparam int PROD_W    = 11;
  localparam int RFREQ_W   = 38;
  localparam int HS_COUNT  = 6;
  localparam int N1_W      = 8;
  localparam int HS_W      = 4;
  localparam int OUT_W     = 56;

  localparam logic [DCO_W-1:0]   DCO_MID_HZ  = 33'd5260000000;
  localparam logic [N1_W-1:0]    N1_MAX      = 8'd128;
  localparam logic [HS_W-1:0]    HS_MAX      = 4'd11;
  localparam logic [HS_W-1:0]    HS_BASE     = 4'd4;
  localparam logic [DCO_W-1:0]   RATIO_LIMIT = 33'd1419;  // (N1_MAX + 1) * HS_MAX
  localparam logic [2:0]         HS_LAST     = 3'(HS_COUNT - 1);

  localparam logic [31:0] CRYSTAL_RST = 32'd114285000;
  localparam logic [31:0] MAX_RST     = 32'd810000000;
  localparam logic [31:0] MIN_RST     = 32'd10000000;

  typedef enum logic [1:0] {
    CFG_CRYSTAL = 2'd0,
    CFG_MAX     = 2'd1,
    CFG_MIN     = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_RANGE = 2'd0,
    ST_SAME  = 2'd1,
    ST_NEW   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_RATIO,
    S_RATIO_CHK,
    S_HS_LOAD,
    S_HS_DIV,
    S_HS_EVAL,
    S_Q_DIV,
    S_MUL,
    S_DONE
  } state_t;

  function automatic logic [HS_W-1:0] hs_value(input logic [2:0] idx);
    logic [HS_W-1:0] v;
    case (idx)
      3'd0:    v = 4'd4;
      3'd1:    v = 4'd5;
      3'd2:    v = 4'd6;
      3'd3:    v = 4'd7;
      3'd4:    v = 4'd9;
      3'd5:    v = 4'd11;
      default: v = 4'd4;
    endcase
    return v;
  endfunction

endpackage

FILE: src/oscillator_divider_and_rfreq_calc_top.sv
// Top level of the oscillator divider selection and rfreq calculation block.
// Depends on oscdiv_pkg and assert_macros.svh.
//
//  channel  | direction | content
//  in_      | slave     | tdata[31:0] target_freq_hz
//  out_     | master    | tdata status, hs_div_code, n1_code, rfreq_word
//  cfg_     | slave     | index 0 crystal, 1 max freq, 2 min freq
//
// A new frequency passes one shared bit-serial restoring divider: 33 steps for the ratio,
// one division for each of the 6 hs candidates and 61 steps for the rounded quotient,
// then 11 shift-add steps for rfreq. Requests outside the limits, equal to the last one
// or with a zero crystal stop at the check; a ratio beyond the n1 range stops after the
// ratio, no usable divider after the last candidate. The next transaction is taken while
// a result waits, then in_tready holds low. Reset is synchronous, active low.
`include "assert_macros.svh"

module oscillator_divider_and_rfreq_calc_top
  import oscdiv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] target_freq_hz
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [1:0] status, [4:2] hs_div_code, [11:5] n1_code,
                                  // [49:12] rfreq_word, [55:50] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  state_t               state_r, state_nxt;
  logic [FREQ_W-1:0]    crystal_r, max_r, min_r, last_r, last_nxt;
  logic [FREQ_W-1:0]    freq_r, freq_nxt;
  logic [DVD_W-1:0]     dvd_r, dvd_nxt;
  logic [FREQ_W-1:0]    rem_r, rem_nxt;
  logic [FREQ_W-1:0]    dsr_r, dsr_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [RATIO_W-1:0]   ratio_r, ratio_nxt;
  logic [2:0]           hs_idx_r, hs_idx_nxt;
  logic [PROD_W-1:0]    best_prod_r, best_prod_nxt;
  logic [HS_W-1:0]      best_hs_r, best_hs_nxt;
  logic [N1_W-1:0]      best_n1_r, best_n1_nxt;
  logic [PROD_W-1:0]    mplier_r, mplier_nxt;
  logic [RFREQ_W-1:0]   acc_r, acc_nxt;
  status_t              res_status_r, res_status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [2:0]           out_hs_r, out_hs_nxt;
  logic [6:0]           out_n1_r, out_n1_nxt;
  logic [RFREQ_W-1:0]   out_rfreq_r, out_rfreq_nxt;

  logic [FREQ_W:0]      shifted;
  logic [FREQ_W+1:0]    diff;
  logic                 qbit;
  logic [FREQ_W-1:0]    rem_step;
  logic [DVD_W-1:0]     dvd_step;
  logic [HS_W-1:0]      hs_cur;
  logic [RATIO_W-1:0]   n1_cand;
  logic [11:0]          prod_cand;
  logic                 n1_ok;
  logic [HS_W-1:0]      hs_off;
  logic [N1_W-1:0]      n1_off;
  logic                 out_held;
  logic                 out_new;
  logic                 div_busy;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_rfreq_r, out_n1_r, out_hs_r, out_status_r};

  assign shifted  = {rem_r, dvd_r[DVD_W-1]};
  assign diff     = {1'b0, shifted} - {2'b00, dsr_r};
  assign qbit     = !diff[FREQ_W+1];
  assign rem_step = qbit ? diff[FREQ_W-1:0] : shifted[FREQ_W-1:0];
  assign dvd_step = {dvd_r[DVD_W-2:0], qbit};

  assign hs_cur    = hs_value(hs_idx_r);
  assign n1_cand   = dvd_r[RATIO_W-1:0];
  assign n1_ok     = (n1_cand != '0) && (n1_cand <= RATIO_W'(N1_MAX));
  assign prod_cand = n1_cand[N1_W-1:0] * hs_cur;
  assign hs_off    = best_hs_r - HS_BASE;
  assign n1_off    = best_n1_r - N1_W'(1);

  assign out_held = out_valid_r && !out_tready;
  assign out_new  = out_valid_r && (out_status_r == ST_NEW);
  assign div_busy = (state_r == S_RATIO) || (state_r == S_HS_DIV) ||
                    (state_r == S_Q_DIV) || (state_r == S_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crystal_r <= CRYSTAL_RST;
      max_r     <= MAX_RST;
      min_r     <= MIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CRYSTAL: crystal_r <= cfg_data;
        CFG_MAX:     max_r     <= cfg_data;
        CFG_MIN:     min_r     <= cfg_data;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    freq_r       <= freq_nxt;
    dvd_r        <= dvd_nxt;
    rem_r        <= rem_nxt;
    dsr_r        <= dsr_nxt;
    cnt_r        <= cnt_nxt;
    ratio_r      <= ratio_nxt;
    hs_idx_r     <= hs_idx_nxt;
    best_prod_r  <= best_prod_nxt;
    best_hs_r    <= best_hs_nxt;
    best_n1_r    <= best_n1_nxt;
    mplier_r     <= mplier_nxt;
    acc_r        <= acc_nxt;
    res_status_r <= res_status_nxt;
    out_status_r <= out_status_nxt;
    out_hs_r     <= out_hs_nxt;
    out_n1_r     <= out_n1_nxt;
    out_rfreq_r  <= out_rfreq_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    last_nxt       = last_r;
    freq_nxt       = freq_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    dsr_nxt        = dsr_r;
    cnt_nxt        = cnt_r;
    ratio_nxt      = ratio_r;
    hs_idx_nxt     = hs_idx_r;
    best_prod_nxt  = best_prod_r;
    best_hs_nxt    = best_hs_r;
    best_n1_nxt    = best_n1_r;
    mplier_nxt     = mplier_r;
    acc_nxt        = acc_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_hs_nxt     = out_hs_r;
    out_n1_nxt     = out_n1_r;
    out_rfreq_nxt  = out_rfreq_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          freq_nxt  = in_tdata;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (freq_r == '0 || freq_r > max_r || freq_r < min_r) begin
          res_status_nxt = ST_RANGE;
          state_nxt      = S_DONE;
        end else if (freq_r == last_r) begin
          res_status_nxt = ST_SAME;
          state_nxt      = S_DONE;
        end else if (crystal_r == '0) begin
          res_status_nxt = ST_RANGE;
          state_nxt      = S_DONE;
        end else begin
          dvd_nxt   = {DCO_MID_HZ, FRAC_BITS'(0)};
          rem_nxt   = '0;
          dsr_nxt   = freq_r;
          cnt_nxt   = CNT_W'(DCO_W);
          state_nxt = S_RATIO;
        end
      end
      S_RATIO: begin
        dvd_nxt = dvd_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = S_RATIO_CHK;
        end
      end
      S_RATIO_CHK: begin
        best_prod_nxt = '0;
        best_hs_nxt   = '0;
        best_n1_nxt   = '0;
        hs_idx_nxt    = '0;
        ratio_nxt     = dvd_r[RATIO_W-1:0];
        if (dvd_r[DCO_W-1:0] >= RATIO_LIMIT) begin
          res_status_nxt = ST_RANGE;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_HS_LOAD;
        end
      end
      S_HS_LOAD: begin
        dvd_nxt   = {ratio_r, (DVD_W - RATIO_W)'(0)};
        rem_nxt   = '0;
        dsr_nxt   = FREQ_W'(hs_cur);
        cnt_nxt   = CNT_W'(RATIO_W);
        state_nxt = S_HS_DIV;
      end
      S_HS_DIV: begin
        dvd_nxt = dvd_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = S_HS_EVAL;
        end
      end
      S_HS_EVAL: begin
        if (n1_ok && prod_cand > {1'b0, best_prod_r}) begin
          best_prod_nxt = prod_cand[PROD_W-1:0];
          best_hs_nxt   = hs_cur;
          best_n1_nxt   = n1_cand[N1_W-1:0];
        end
        if (hs_idx_r == HS_LAST) begin
          if (best_prod_nxt == '0) begin
            res_status_nxt = ST_RANGE;
            state_nxt      = S_DONE;
          end else begin
            dvd_nxt   = {1'b0, freq_r, FRAC_BITS'(0)} +
                        {(DVD_W - FREQ_W + 1)'(0), crystal_r[FREQ_W-1:1]};
            rem_nxt   = '0;
            dsr_nxt   = crystal_r;
            cnt_nxt   = CNT_W'(DVD_W);
            state_nxt = S_Q_DIV;
          end
        end else begin
          hs_idx_nxt = hs_idx_r + 3'd1;
          state_nxt  = S_HS_LOAD;
        end
      end
      S_Q_DIV: begin
        dvd_nxt = dvd_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          acc_nxt    = '0;
          mplier_nxt = best_prod_r;
          cnt_nxt    = CNT_W'(PROD_W);
          state_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        if (mplier_r[0]) begin
          acc_nxt = acc_r + dvd_r[RFREQ_W-1:0];
        end
        dvd_nxt    = {dvd_r[DVD_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[PROD_W-1:1]};
        cnt_nxt    = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          res_status_nxt = ST_NEW;
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          if (res_status_r == ST_NEW) begin
            out_hs_nxt    = hs_off[2:0];
            out_n1_nxt    = n1_off[6:0];
            out_rfreq_nxt = acc_r;
            last_nxt      = freq_r;
          end else begin
            out_hs_nxt    = '0;
            out_n1_nxt    = '0;
            out_rfreq_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `OSC_ASSERT(a_zero_fields, clk, rst_n, (out_valid_r && !out_new) |-> (out_tdata[49:2] == '0))
  `OSC_ASSERT(a_last_update, clk, rst_n, !$stable(last_r) |-> (out_new && !$past(out_held)))
  `OSC_ASSERT_NEVER(a_cnt_live, clk, rst_n, div_busy && cnt_r == '0)
  `OSC_ASSERT(a_new_n1, clk, rst_n, (state_r == S_DONE && res_status_r == ST_NEW) |-> n1_off < N1_MAX)

endmodule
